[sv/pidtic_pkg.sv]
// ----------------------------------------------------------------------------
// pidtic_pkg
// Shared widths, register indexes and the datapath result type for the
// trapezoid-integral pid controller.
// ----------------------------------------------------------------------------
package pidtic_pkg;

  // field widths
  localparam int ErrW   = 16;
  localparam int GainW  = 16;
  localparam int LimW   = 31;
  localparam int AccW   = 32;
  localparam int DriveW = 24;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 31;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_INTEG_GAIN  = 2'd1,
    REG_DERIV_GAIN  = 2'd2,
    REG_INTEG_LIMIT = 2'd3
  } cfg_reg_t;

  // function codes of an input beat
  localparam logic FUNC_PROCESS = 1'b0;
  localparam logic FUNC_CLEAR   = 1'b1;

  // result of one pass through the datapath
  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     saturated;
    logic signed [AccW-1:0]   integ_next;
  } calc_res_t;

endpackage

[sv/pidtic_calc.sv]
// ----------------------------------------------------------------------------
// pidtic_calc
// Combinational pid datapath: three gain products, trapezoid integral with
// clamp, sum, shift by 8 and saturation to the drive range.
// ----------------------------------------------------------------------------
module pidtic_calc (
  input  logic [pidtic_pkg::GainW-1:0]       prop_gain,
  input  logic [pidtic_pkg::GainW-1:0]       integ_gain,
  input  logic [pidtic_pkg::GainW-1:0]       deriv_gain,
  input  logic [pidtic_pkg::LimW-1:0]        integ_limit,
  input  logic signed [pidtic_pkg::ErrW-1:0] err,
  input  logic signed [pidtic_pkg::ErrW-1:0] prev_err,
  input  logic signed [pidtic_pkg::AccW-1:0] integ_acc,
  output pidtic_pkg::calc_res_t              res
);
  import pidtic_pkg::*;

  localparam logic signed [27:0] YMax = 28'sd8388607;
  localparam logic signed [27:0] YMin = -28'sd8388608;

  logic signed [16:0] e_sum;
  logic signed [16:0] e_diff;
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [16:0] kd_s;
  logic signed [32:0] p_prod;
  logic signed [33:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [34:0] i_raw;
  logic signed [34:0] lim_pos;
  logic signed [34:0] lim_neg;
  logic signed [34:0] i_clamp;
  logic signed [35:0] pid_sum;
  logic signed [27:0] y_full;

  // error sum and difference at full width
  assign e_sum  = {err[ErrW-1], err} + {prev_err[ErrW-1], prev_err};
  assign e_diff = {err[ErrW-1], err} - {prev_err[ErrW-1], prev_err};

  // gains as non-negative signed operands
  assign kp_s = {1'b0, prop_gain};
  assign ki_s = {1'b0, integ_gain};
  assign kd_s = {1'b0, deriv_gain};

  // three independent products
  assign p_prod = kp_s * $signed({err[ErrW-1], err});
  assign i_prod = {{17{ki_s[16]}}, ki_s} * {{17{e_sum[16]}}, e_sum};
  assign d_prod = {{17{kd_s[16]}}, kd_s} * {{17{e_diff[16]}}, e_diff};

  // trapezoid update, half rounds toward minus infinity
  assign i_raw   = {{3{integ_acc[AccW-1]}}, integ_acc} + {{2{i_prod[33]}}, i_prod[33:1]};
  assign lim_pos = {4'b0000, integ_limit};
  assign lim_neg = -lim_pos;

  // integral clamp
  always_comb begin
    if (i_raw > lim_pos) begin
      i_clamp = lim_pos;
    end else if (i_raw < lim_neg) begin
      i_clamp = lim_neg;
    end else begin
      i_clamp = i_raw;
    end
  end

  // sum of terms, arithmetic shift by 8
  assign pid_sum = {{3{p_prod[32]}}, p_prod} + {i_clamp[34], i_clamp}
                 + {{2{d_prod[33]}}, d_prod};
  assign y_full  = pid_sum[35:8];

  // saturate to the drive range
  always_comb begin
    res.integ_next = i_clamp[AccW-1:0];
    if (y_full > YMax) begin
      res.drive     = YMax[DriveW-1:0];
      res.saturated = 1'b1;
    end else if (y_full < YMin) begin
      res.drive     = YMin[DriveW-1:0];
      res.saturated = 1'b1;
    end else begin
      res.drive     = y_full[DriveW-1:0];
      res.saturated = 1'b0;
    end
  end

endmodule

[sv/pid_tustin_integral_clamp.sv]
// ----------------------------------------------------------------------------
// pid_tustin_integral_clamp
// Discrete pid controller with trapezoid integral and clamped accumulator.
// ----------------------------------------------------------------------------
// Takes one beat per cycle unless stalled: a process beat (func 0) carries a
// signed error sample and yields one drive beat when the output side is free;
// a clear beat (func 1) zeroes the integral and yields nothing. A beat sits in
// an input register, passes once through the product/clamp/saturate datapath
// and lands in the output register, and the integral and last error update in
// that same cycle, so the next sample can follow immediately at one beat per
// cycle unless the output stalls. The input side keeps accepting while a
// result waits in the output register, until the input register is also full.
// Gains and the integral limit are written over the config port (always
// ready); users must do so only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module pid_tustin_integral_clamp (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidtic_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [pidtic_pkg::CfgDataW-1:0]      cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic signed [pidtic_pkg::ErrW-1:0]   error_sample,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pidtic_pkg::DriveW-1:0] drive,
  output logic                                 saturated
);
  import pidtic_pkg::*;

  logic [GainW-1:0]       prop_gain;
  logic [GainW-1:0]       integ_gain;
  logic [GainW-1:0]       deriv_gain;
  logic [LimW-1:0]        integ_limit;
  logic signed [ErrW-1:0] last_error;
  logic signed [AccW-1:0] integ_acc;
  logic                   in_full;
  logic                   func_q;
  logic signed [ErrW-1:0] err_q;
  logic                   out_free;
  logic                   advance;
  logic                   in_take;
  calc_res_t              calc_res;

  // handshake control
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign advance   = in_full && ((func_q == FUNC_CLEAR) || out_free);
  assign in_stall  = in_full && !advance;
  assign in_take   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:   prop_gain   <= cfg_data[GainW-1:0];
        REG_INTEG_GAIN:  integ_gain  <= cfg_data[GainW-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data[GainW-1:0];
        REG_INTEG_LIMIT: integ_limit <= cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_q <= func;
      err_q  <= error_sample;
    end
  end

  // datapath
  pidtic_calc u_calc (
    .prop_gain   (prop_gain),
    .integ_gain  (integ_gain),
    .deriv_gain  (deriv_gain),
    .integ_limit (integ_limit),
    .err         (err_q),
    .prev_err    (last_error),
    .integ_acc   (integ_acc),
    .res         (calc_res)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      integ_acc  <= '0;
    end else if (advance) begin
      if (func_q == FUNC_CLEAR) begin
        integ_acc <= '0;
      end else begin
        integ_acc  <= calc_res.integ_next;
        last_error <= err_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (func_q == FUNC_PROCESS)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (func_q == FUNC_PROCESS)) begin
      drive     <= calc_res.drive;
      saturated <= calc_res.saturated;
    end
  end

endmodule

[sv/pidtic_checker.sv]
// ----------------------------------------------------------------------------
// pidtic_checker
// Port-level checks for the pid controller, bound to the top level.
// ----------------------------------------------------------------------------
module pidtic_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [pidtic_pkg::DriveW-1:0] drive,
  input logic                                 saturated
);
  import pidtic_pkg::*;

  localparam logic signed [DriveW-1:0] DMax = 24'sd8388607;
  localparam logic signed [DriveW-1:0] DMin = -24'sd8388608;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive) && $stable(saturated))
    else $error("output beat changed while stalled");

  // a clipped drive sits at one end of its range
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (drive == DMax) || (drive == DMin))
    else $error("saturated flag with drive off the rails");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output empty");

endmodule

bind pid_tustin_integral_clamp pidtic_checker u_pidtic_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .saturated (saturated)
);
